@@ design/sensor_read_sequencer_defines.svh @@
// Assertion macros used by the design-side checker file.
`ifndef SENSOR_READ_SEQUENCER_DEFINES_SVH
`define SENSOR_READ_SEQUENCER_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define SQR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sqr assertion failed");

// Clocked property, checked during reset as well.
`define SQR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sqr assertion failed");

`endif

@@ design/sqr_pkg.sv @@
package sqr_pkg;

    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 11;
    localparam int CFG_W    = 16;
    localparam int MS_W     = 26;   // 65535 s * 1000 fits in 26 bits
    localparam int IDX_W    = 2;

    localparam int unsigned MS_PER_S = 1000;
    localparam int unsigned RETRY_MS = 2000;

    localparam int unsigned PERIOD_S_RST = 60;
    localparam int unsigned SETTLE_S_RST = 5;
    localparam int unsigned WINDOW_S_RST = 10;

    localparam logic [IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SETTLE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WINDOW = 2'd2;

    typedef enum logic [1:0] {
        PH_OFF    = 2'd0,
        PH_SETTLE = 2'd1,
        PH_READ   = 2'd2,
        PH_REPORT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MS_W-1:0] period_ms;
        logic [MS_W-1:0] settle_ms;
        logic [MS_W-1:0] window_ms;
    } sqr_cfg_t;

    typedef struct packed {
        phase_t                    phase;
        logic                      no_reading;
        logic signed [TEMP_W-1:0]  meas_tenths;
        logic                      meas_valid;
        logic                      read_strobe;
    } sqr_result_t;

    // (t_now - since) mod 2^32 >= ms
    function automatic logic elapsed(logic [TIME_W-1:0] t_now,
                                     logic [TIME_W-1:0] since,
                                     logic [MS_W-1:0]   ms);
        logic [TIME_W-1:0] diff;
        diff = t_now - since;
        return diff >= {{(TIME_W-MS_W){1'b0}}, ms};
    endfunction

endpackage

@@ design/sqr_cfg.sv @@
module sqr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sqr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sqr_pkg::CFG_W-1:0]   cfg_wdata,
    output sqr_pkg::sqr_cfg_t           cfg
);
    import sqr_pkg::*;

    logic [MS_W-1:0] period_ms_reg, settle_ms_reg, window_ms_reg;
    logic [MS_W-1:0] wdata_ms;

    // Scale seconds to ms at write time; the datapath then only compares.
    assign wdata_ms = MS_W'(cfg_wdata) * MS_W'(MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_ms_reg <= MS_W'(PERIOD_S_RST * MS_PER_S);
            settle_ms_reg <= MS_W'(SETTLE_S_RST * MS_PER_S);
            window_ms_reg <= MS_W'(WINDOW_S_RST * MS_PER_S);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PERIOD: period_ms_reg <= wdata_ms;
                CFG_SETTLE: settle_ms_reg <= wdata_ms;
                CFG_WINDOW: window_ms_reg <= wdata_ms;
                default: ;
            endcase
        end
    end

    assign cfg.period_ms = period_ms_reg;
    assign cfg.settle_ms = settle_ms_reg;
    assign cfg.window_ms = window_ms_reg;

endmodule

@@ design/sqr_fsm.sv @@
module sqr_fsm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [sqr_pkg::TIME_W-1:0]          now_ms,
    input  logic                                sample_ok,
    input  logic signed [sqr_pkg::TEMP_W-1:0]   sample_tenths,
    input  sqr_pkg::sqr_cfg_t                   cfg,
    output sqr_pkg::sqr_result_t                result
);
    import sqr_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic [TIME_W-1:0]         cycle_start_reg, cycle_start_next;
    logic [TIME_W-1:0]         settle_start_reg, settle_start_next;
    logic [TIME_W-1:0]         last_try_reg, last_try_next;
    logic signed [TEMP_W-1:0]  held_temp_reg, held_temp_next;
    logic                      held_valid_reg, held_valid_next;

    logic el_period, el_settle, el_window, try_now;

    assign el_period = elapsed(now_ms, cycle_start_reg, cfg.period_ms);
    assign el_settle = elapsed(now_ms, settle_start_reg, cfg.settle_ms);
    assign el_window = elapsed(now_ms, cycle_start_reg, cfg.window_ms);
    assign try_now   = !held_valid_reg &&
                       elapsed(now_ms, last_try_reg, MS_W'(RETRY_MS));

    // next state
    always_comb begin
        phase_next        = phase_reg;
        cycle_start_next  = cycle_start_reg;
        settle_start_next = settle_start_reg;
        last_try_next     = last_try_reg;
        held_temp_next    = held_temp_reg;
        held_valid_next   = held_valid_reg;
        case (phase_reg)
            PH_OFF: begin
                if (el_period) begin
                    settle_start_next = now_ms;
                    cycle_start_next  = now_ms;
                    held_valid_next   = 1'b0;
                    held_temp_next    = '0;
                    last_try_next     = '0;
                    phase_next        = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (el_settle) begin
                    phase_next = PH_READ;
                end
            end
            PH_READ: begin
                if (try_now) begin
                    last_try_next = now_ms;
                    if (sample_ok) begin
                        held_temp_next  = sample_tenths;
                        held_valid_next = 1'b1;
                    end
                end
                if (held_valid_reg || (try_now && sample_ok) || el_window) begin
                    phase_next = PH_REPORT;
                end
            end
            PH_REPORT: begin
                cycle_start_next = now_ms;
                phase_next       = PH_OFF;
            end
            default: phase_next = PH_OFF;
        endcase
    end

    // outputs
    always_comb begin
        result.read_strobe = (phase_reg == PH_READ) && try_now;
        result.meas_valid  = (phase_reg == PH_REPORT) && held_valid_reg;
        result.meas_tenths = result.meas_valid ? held_temp_reg : '0;
        result.no_reading  = (phase_reg == PH_REPORT) && !held_valid_reg;
        result.phase       = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_OFF;
            cycle_start_reg  <= '0;
            settle_start_reg <= '0;
            last_try_reg     <= '0;
            held_temp_reg    <= '0;
            held_valid_reg   <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            cycle_start_reg  <= cycle_start_next;
            settle_start_reg <= settle_start_next;
            last_try_reg     <= last_try_next;
            held_temp_reg    <= held_temp_next;
            held_valid_reg   <= held_valid_next;
        end
    end

endmodule

@@ design/sensor_read_sequencer.sv @@
// Pipeline: an input register, then a result register, from s_ transfer to m_tvalid.
// Throughput: one tick per cycle while m_tready does not stall the result slot; every phase
//   decision is one subtract/compare pass on the state registers between the two registers.
// Reset (aresetn low, synchronous): phase off, timestamps and held reading
//   cleared, config back to period 60 s, settle 5 s, window 10 s; both
//   pipeline slots empty.
module sensor_read_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input ticks
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [31:0] now_ms, [32] sample_ok, [43:33] sample_tenths, [47:44] zero
    input  logic [47:0]                 s_tdata,
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] read_strobe, [1] meas_valid, [12:2] meas_tenths, [13] no_reading,
    // [15:14] phase
    output logic [15:0]                 m_tdata,
    // configuration writes
    input  logic                        cfg_wr_en,
    input  logic [sqr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sqr_pkg::CFG_W-1:0]   cfg_wdata
);
    import sqr_pkg::*;

    sqr_cfg_t     cfg;
    sqr_result_t  result;

    // input register stage
    logic                      in_valid_reg, in_valid_next;
    logic [TIME_W-1:0]         now_ms_reg;
    logic                      sample_ok_reg;
    logic signed [TEMP_W-1:0]  sample_tenths_reg;

    // result register stage
    logic                      out_valid_reg, out_valid_next;
    sqr_result_t               result_reg;

    logic s_xfer;    // input transfer this cycle
    logic advance;   // result slot free or being drained
    logic step;      // tick in the input register is processed now

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    // The input slot refills in the same cycle that its tick moves on.
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            now_ms_reg        <= s_tdata[31:0];
            sample_ok_reg     <= s_tdata[32];
            sample_tenths_reg <= s_tdata[43:33];
        end
        if (step) begin
            result_reg <= result;
        end
    end

    sqr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Phase sequencer: state updates only when a tick is processed.
    sqr_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .now_ms        (now_ms_reg),
        .sample_ok     (sample_ok_reg),
        .sample_tenths (sample_tenths_reg),
        .cfg           (cfg),
        .result        (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

@@ design/sqr_checker.sv @@
`include "sensor_read_sequencer_defines.svh"

module sqr_sva (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);
    import sqr_pkg::*;

    // stalled result holds
    `SQR_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // a report and a missed reading never coincide
    `SQR_ASSERT(a_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[1] && m_tdata[13]))
    // a report always returns to off
    `SQR_ASSERT(a_rep_off, aclk, aresetn, m_tvalid && (m_tdata[1] || m_tdata[13]) |-> m_tdata[15:14] == PH_OFF)
    // no temperature without a measurement
    `SQR_ASSERT(a_temp_zero, aclk, aresetn, m_tvalid && !m_tdata[1] |-> m_tdata[12:2] == 11'd0)
    // nothing comes out right after reset
    `SQR_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind sensor_read_sequencer sqr_sva u_sqr_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/sqr_checker.sv @@
module sqr_checker import sqr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // [31:0] now_ms, [32] sample_ok, [43:33] sample_tenths, [47:44] zero
    input  logic [47:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    // [0] read_strobe, [1] meas_valid, [12:2] meas_tenths, [13] no_reading,
    // [15:14] phase
    input  logic [15:0]      m_tdata,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               pending,
    output int               errors
);

    // timing registers, held in seconds as written (the block holds milliseconds)
    logic [CFG_W-1:0]  period_s;
    logic [CFG_W-1:0]  settle_s;
    logic [CFG_W-1:0]  window_s;

    // sequencer state
    phase_t            ph;
    logic [TIME_W-1:0] t_cycle;
    logic [TIME_W-1:0] t_settle;
    logic [TIME_W-1:0] t_try;
    logic [TEMP_W-1:0] held_tenths;
    logic              held_ok;

    sqr_result_t       expected_results[$];
    int                fail_cnt = 0;
    int                depth = 0;

    assign pending = depth;
    assign errors  = fail_cnt;

    function automatic logic [TIME_W-1:0] secs_to_ms(logic [CFG_W-1:0] secs);
        return {16'd0, secs} * 32'd1000;
    endfunction

    // wrapping difference, compared unsigned
    function automatic logic has_passed(logic [TIME_W-1:0] t_now,
                                        logic [TIME_W-1:0] since,
                                        logic [TIME_W-1:0] span_ms);
        logic [TIME_W-1:0] diff;
        diff = t_now - since;
        return diff >= span_ms;
    endfunction

    task automatic step_sequencer(input  logic [TIME_W-1:0] t_now,
                                  input  logic              ok,
                                  input  logic [TEMP_W-1:0] smp,
                                  output sqr_result_t       r);
        r = '0;
        case (ph)
            PH_OFF: begin
                if (has_passed(t_now, t_cycle, secs_to_ms(period_s))) begin
                    t_settle    = t_now;
                    t_cycle     = t_now;
                    held_ok     = 1'b0;
                    held_tenths = '0;
                    t_try       = '0;
                    ph          = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (has_passed(t_now, t_settle, secs_to_ms(settle_s)))
                    ph = PH_READ;
            end
            PH_READ: begin
                if (!held_ok && has_passed(t_now, t_try, RETRY_MS)) begin
                    t_try         = t_now;
                    r.read_strobe = 1'b1;
                    if (ok) begin
                        held_tenths = smp;
                        held_ok     = 1'b1;
                    end
                end
                if (held_ok || has_passed(t_now, t_cycle, secs_to_ms(window_s)))
                    ph = PH_REPORT;
            end
            default: begin
                if (held_ok) begin
                    r.meas_valid  = 1'b1;
                    r.meas_tenths = held_tenths;
                end else begin
                    r.no_reading = 1'b1;
                end
                t_cycle = t_now;
                ph      = PH_OFF;
            end
        endcase
        r.phase = ph;
    endtask

    task automatic compare_result(input sqr_result_t want, input sqr_result_t got);
        if (got.read_strobe !== want.read_strobe) begin
            $error("read_strobe: expected %0d, got %0d", want.read_strobe, got.read_strobe);
            fail_cnt++;
        end
        if (got.meas_valid !== want.meas_valid) begin
            $error("meas_valid: expected %0d, got %0d", want.meas_valid, got.meas_valid);
            fail_cnt++;
        end
        if (got.meas_tenths !== want.meas_tenths) begin
            $error("meas_tenths: expected %0d, got %0d", want.meas_tenths, got.meas_tenths);
            fail_cnt++;
        end
        if (got.no_reading !== want.no_reading) begin
            $error("no_reading: expected %0d, got %0d", want.no_reading, got.no_reading);
            fail_cnt++;
        end
        if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        sqr_result_t got;
        sqr_result_t nxt;
        if (!aresetn) begin
            period_s    = CFG_W'(PERIOD_S_RST);
            settle_s    = CFG_W'(SETTLE_S_RST);
            window_s    = CFG_W'(WINDOW_S_RST);
            ph          = PH_OFF;
            t_cycle     = '0;
            t_settle    = '0;
            t_try       = '0;
            held_tenths = '0;
            held_ok     = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_strobe = m_tdata[0];
                got.meas_valid  = m_tdata[1];
                got.meas_tenths = m_tdata[12:2];
                got.no_reading  = m_tdata[13];
                got.phase       = phase_t'(m_tdata[15:14]);
                if (expected_results.size() == 0) begin
                    $error("result transfer %h with nothing expected", m_tdata);
                    fail_cnt++;
                end else begin
                    compare_result(expected_results.pop_front(), got);
                end
            end
            if (s_tvalid && s_tready) begin
                step_sequencer(s_tdata[31:0], s_tdata[32], s_tdata[43:33], nxt);
                expected_results.push_back(nxt);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PERIOD: period_s = cfg_wdata;
                    CFG_SETTLE: settle_s = cfg_wdata;
                    CFG_WINDOW: window_s = cfg_wdata;
                    default: ;
                endcase
            end
        end
        depth = expected_results.size();
    end

endmodule

@@ verif/tb.sv @@
module tb;
    import sqr_pkg::*;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 200;   // long receiver back-pressure stretch
    localparam int DRAIN       = 10;    // leave room for strays
    localparam int GAP_MAX     = 17;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    // [31:0] now_ms, [32] sample_ok, [43:33] sample_tenths, [47:44] zero
    logic [47:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // [0] read_strobe, [1] meas_valid, [12:2] meas_tenths, [13] no_reading,
    // [15:14] phase
    logic [15:0]      m_tdata;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int               pending;
    int               errors;

    // idling controls shared between stimulus and the result sink
    int               tx_max;
    int               rx_max;
    bit               hold_req;
    logic [31:0]      cursor;      // running millisecond clock for ticks
    int               idle_cycles = 0;

    sensor_read_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sqr_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .errors    (errors)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result sink: random stall before each transfer, or one long hold-off
    // on request so the two pipeline slots fill and s_tready drops.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                stall = $urandom_range(0, rx_max);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One tick transfer. Starts right after the previous transfer's edge, so
    // s_tvalid is either held for back-to-back or dropped for a gap.
    task automatic send_tick(input logic [31:0] t_now, input logic ok, input int tenths);
        int gap;
        gap = $urandom_range(0, tx_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tenths[TEMP_W-1:0], ok, t_now};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic tick_at(input logic [31:0] t_now, input logic ok, input int tenths);
        cursor = t_now;
        send_tick(t_now, ok, tenths);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    // Leaves us on a falling edge, block idle.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    // Back-to-back writes of all three timers plus a junk write to the
    // unmapped index; called on a falling edge while the block is idle.
    task automatic set_timing(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] stl,
                              input logic [CFG_W-1:0] win);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PERIOD;
        cfg_wdata <= per;
        @(negedge aclk);
        cfg_index <= CFG_SETTLE;
        cfg_wdata <= stl;
        @(negedge aclk);
        cfg_index <= CFG_WINDOW;
        cfg_wdata <= win;
        @(negedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= CFG_W'($urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random ticks: time moves mostly in small steps so every phase is
    // walked through, with repeats of the same time and rare wild jumps.
    task automatic run_ticks(input int n, input logic [31:0] dt_max);
        int          pick;
        int          tenths;
        logic [31:0] dt_ms;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                dt_ms = '0;
            end else if (pick < 14) begin
                dt_ms = $urandom;
            end else begin
                dt_ms = $urandom_range(0, dt_max);
            end
            // mostly plausible temperatures, some raw 11-bit codes
            if ($urandom_range(0, 4) == 0) begin
                tenths = $urandom_range(0, 2047);
            end else begin
                tenths = int'($urandom_range(0, 1200)) - 400;
            end
            cursor = cursor + dt_ms;
            send_tick(cursor, $urandom_range(0, 99) < 35, tenths);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_PERIOD;
        cfg_wdata = '0;
        tx_max    = GAP_MAX;
        rx_max    = GAP_MAX;
        hold_req  = 1'b0;
        cursor    = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // --- directed: reset timing 60 / 5 / 10 s ---
        tick_at(32'd0, 1'b1, 0);            // period not reached, stays off
        tick_at(32'd60000, 1'b0, 5);        // cycle starts, settle
        tick_at(32'd65000, 1'b1, 0);        // settle done, into read
        tick_at(32'd65000, 1'b1, 0);        // first poll, exact zero is a valid reading
        tick_at(32'd65001, 1'b0, 100);      // report of 0.0

        // --- directed: all timers at minimum-ish, window 1 s ---
        quiesce();
        set_timing(16'd0, 16'd0, 16'd1);
        tick_at(32'd100, 1'b1, 300);        // period 0: starts at once
        tick_at(32'd100, 1'b1, 300);        // settle 0: straight to read
        tick_at(32'd600, 1'b1, 300);        // retry timer cleared to 0: no poll below 2000 ms
        tick_at(32'd1100, 1'b1, 300);       // window gone, no strobe
        tick_at(32'd1100, 1'b1, 300);       // cycle ends with no reading
        tick_at(32'd1200, 1'b0, 0);
        tick_at(32'd1200, 1'b0, 0);
        tick_at(32'd2500, 1'b0, -400);      // poll fails, window gone
        tick_at(32'd2500, 1'b1, 800);       // no reading again

        // --- directed: max period and window, retry spacing ---
        quiesce();
        set_timing(16'hFFFF, 16'd0, 16'hFFFF);
        tick_at(32'd65537499, 1'b1, 800);   // one ms short of the period
        tick_at(32'd65537500, 1'b1, 800);   // start
        tick_at(32'd65537500, 1'b0, 0);     // into read
        tick_at(32'd65537500, 1'b0, 0);     // poll, sensor fails
        tick_at(32'd65539499, 1'b1, 5);     // 1999 ms later: too soon to retry
        tick_at(32'd65539500, 1'b1, -1024); // retry, out-of-range code is held as is
        tick_at(32'd65539500, 1'b0, 0);     // report it

        // --- random phases ---
        for (int k = 0; k < 10; k++) begin
            logic [31:0] dt_max;
            quiesce();
            if (k == 3) begin
                set_timing(16'hFFFF, 16'hFFFF, 16'd0);
                dt_max = 32'd70_000_000;
            end else if (k == 7) begin
                set_timing(16'd0, 16'hFFFF, 16'hFFFF);
                dt_max = 32'd70_000_000;
            end else begin
                set_timing(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
                           CFG_W'($urandom_range(0, 12)));
                dt_max = 32'd1500;
            end
            // run some phases across the 2^32 wrap of the ms clock
            if (k % 4 == 1)
                cursor = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            // every third phase runs with no random idling on either side
            tx_max = (k % 3 == 2) ? 0 : GAP_MAX;
            rx_max = (k % 3 == 2) ? 0 : GAP_MAX;
            if (k == 5) begin
                // sender streams back-to-back while the sink holds off
                tx_max   = 0;
                hold_req = 1'b1;
            end
            run_ticks(100, dt_max);
        end

        quiesce();
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
